// ----- sv/btlv_pkg.sv -----
// Shared types and constants for the BER TLV header parser.
// Used by every module of the block; depends on nothing else.
package btlv_pkg;

  localparam int TAG_BITS_DEFAULT = 32;
  localparam int MAX_LENGTH_OCTETS_DEFAULT = 8;

  localparam int TAG_OUT_W = 32;
  localparam int LEN_W = 64;
  localparam int LEFT_W = 4;

  // Parse phases.
  localparam logic [1:0] PH_IDENT = 2'd0;
  localparam logic [1:0] PH_TAG = 2'd1;
  localparam logic [1:0] PH_LEN0 = 2'd2;
  localparam logic [1:0] PH_LENX = 2'd3;

  // Error codes.
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_PRIM_INDEF = 2'd1;
  localparam logic [1:0] ERR_TOO_MANY_OCTETS = 2'd2;

  localparam logic [4:0] TAG_LONG_FORM = 5'b11111;
  localparam logic [6:0] LEN_INDEFINITE = 7'b0000000;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       restart;
  } item_t;

  typedef struct packed {
    logic [1:0]           id_class;
    logic                 constructed;
    logic [TAG_OUT_W-1:0] tag_number;
    logic [LEN_W-1:0]     content_length;
    logic                 indefinite;
    logic [7:0]           header_size;
    logic [1:0]           error_code;
  } hdr_result_t;

endpackage

// ----- sv/btlv_in_stage.sv -----
// Input register of the BER TLV header parser.
// Holds one item until the parse step consumes it; uses btlv_pkg.
module btlv_in_stage import btlv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] header_byte,
  input  logic       restart,
  input  logic       take,
  output logic       item_valid,
  output item_t      item
);

  // The register refills in the same cycle it is drained.
  assign in_stall = item_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.header_byte <= header_byte;
      item.restart <= restart;
    end
  end

endmodule

// ----- sv/btlv_step.sv -----
// Combinational parse step of the BER TLV header parser: next state and
// the result for one header byte. Uses btlv_pkg.
module btlv_step import btlv_pkg::*; #(
  parameter int TAG_BITS = TAG_BITS_DEFAULT,
  parameter int MAX_LENGTH_OCTETS = MAX_LENGTH_OCTETS_DEFAULT
) (
  input  item_t               item,
  input  logic [1:0]          phase,
  input  logic [1:0]          saved_class,
  input  logic                saved_constructed,
  input  logic [TAG_BITS-1:0] tag_acc,
  input  logic [LEN_W-1:0]    len_acc,
  input  logic [LEFT_W-1:0]   octets_left,
  input  logic [7:0]          byte_count,
  output logic [1:0]          phase_next,
  output logic [1:0]          saved_class_next,
  output logic                saved_constructed_next,
  output logic [TAG_BITS-1:0] tag_acc_next,
  output logic [LEN_W-1:0]    len_acc_next,
  output logic [LEFT_W-1:0]   octets_left_next,
  output logic [7:0]          byte_count_next,
  output logic                emit,
  output hdr_result_t         result
);

  logic [1:0]        ph;
  logic [7:0]        b;
  logic [7:0]        count_inc;
  logic [LEN_W-1:0]  len_shift;
  logic [LEFT_W-1:0] left_dec;
  logic [LEN_W-1:0]  res_len;
  logic              res_indef;
  logic [1:0]        res_err;
  logic [63:0]       tag_wide;

  assign b = item.header_byte;
  assign count_inc = (byte_count != 8'd255) ? byte_count + 8'd1 : byte_count;
  assign len_shift = {len_acc[LEN_W-9:0], b};
  assign left_dec = (octets_left != '0) ? octets_left - LEFT_W'(1) : octets_left;
  assign tag_wide = 64'(tag_acc);

  always_comb begin
    ph = item.restart ? PH_IDENT : phase;
    phase_next = ph;
    saved_class_next = saved_class;
    saved_constructed_next = saved_constructed;
    tag_acc_next = tag_acc;
    len_acc_next = len_acc;
    octets_left_next = octets_left;
    byte_count_next = count_inc;
    emit = 1'b0;
    res_len = '0;
    res_indef = 1'b0;
    res_err = ERR_NONE;
    unique case (ph)
      PH_IDENT: begin
        saved_class_next = b[7:6];
        saved_constructed_next = b[5];
        len_acc_next = '0;
        octets_left_next = '0;
        byte_count_next = 8'd1;
        if (b[4:0] == TAG_LONG_FORM) begin
          phase_next = PH_TAG;
          tag_acc_next = '0;
        end else begin
          phase_next = PH_LEN0;
          tag_acc_next = TAG_BITS'(b[4:0]);
        end
      end
      PH_TAG: begin
        tag_acc_next = {tag_acc[TAG_BITS-8:0], b[6:0]};
        if (!b[7]) begin
          phase_next = PH_LEN0;
        end
      end
      PH_LEN0: begin
        if (!b[7]) begin
          emit = 1'b1;
          res_len = LEN_W'(b[6:0]);
        end else if (b[6:0] == LEN_INDEFINITE) begin
          emit = 1'b1;
          res_indef = 1'b1;
          res_err = saved_constructed ? ERR_NONE : ERR_PRIM_INDEF;
        end else if (b[6:0] > 7'(MAX_LENGTH_OCTETS)) begin
          emit = 1'b1;
          res_err = ERR_TOO_MANY_OCTETS;
        end else begin
          len_acc_next = '0;
          octets_left_next = b[LEFT_W-1:0];
          phase_next = PH_LENX;
        end
      end
      PH_LENX: begin
        len_acc_next = len_shift;
        octets_left_next = left_dec;
        if (left_dec == '0) begin
          emit = 1'b1;
          res_len = len_shift;
        end
      end
      default: begin
        phase_next = PH_IDENT;
      end
    endcase
    if (emit) begin
      phase_next = PH_IDENT;
      octets_left_next = '0;
    end
  end

  assign result.id_class = saved_class;
  assign result.constructed = saved_constructed;
  assign result.tag_number = tag_wide[TAG_OUT_W-1:0];
  assign result.content_length = res_len;
  assign result.indefinite = res_indef;
  assign result.header_size = byte_count_next;
  assign result.error_code = res_err;

endmodule

// ----- sv/ber_tlv_header_parser_unit.sv -----
// Top level of the BER TLV header parser: input register, parse state,
// and result register. Uses btlv_pkg, btlv_in_stage and btlv_step.
//
// Usage: header bytes of an X.690 BER value enter on the input channel
// (in_valid, in_stall, header_byte, restart), one byte per item. A set
// restart bit drops any partial header and treats the byte as an
// identifier octet. One result item leaves on the output channel
// (out_valid, out_stall and the result fields) when a header completes or
// an error is found; identifier, tag and intermediate length bytes give
// no result.
// Path: an accepted byte is held in the input register, parsed from it
// when the result register can take the output, and its result is loaded
// into the result register, which drives the output ports.
// Throughput: one byte per cycle while no result waits under out_stall.
// The parse state update is one shift-or step in the parse logic, so
// consecutive bytes follow back to back.
// Stall: while a result waits under out_stall, the input register holds
// its byte and in_stall rises once that register is full.
// Reset: rst is synchronous; it empties both registers and returns the
// parser to expecting an identifier octet.
module ber_tlv_header_parser_unit import btlv_pkg::*; #(
  parameter int TAG_BITS = TAG_BITS_DEFAULT,
  parameter int MAX_LENGTH_OCTETS = MAX_LENGTH_OCTETS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           header_byte,
  input  logic                 restart,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           id_class,
  output logic                 constructed,
  output logic [TAG_OUT_W-1:0] tag_number,
  output logic [LEN_W-1:0]     content_length,
  output logic                 indefinite,
  output logic [7:0]           header_size,
  output logic [1:0]           error_code
);

  item_t               item;
  logic                item_valid;
  logic                take;
  logic [1:0]          phase;
  logic [1:0]          phase_next;
  logic [1:0]          saved_class;
  logic [1:0]          saved_class_next;
  logic                saved_constructed;
  logic                saved_constructed_next;
  logic [TAG_BITS-1:0] tag_acc;
  logic [TAG_BITS-1:0] tag_acc_next;
  logic [LEN_W-1:0]    len_acc;
  logic [LEN_W-1:0]    len_acc_next;
  logic [LEFT_W-1:0]   octets_left;
  logic [LEFT_W-1:0]   octets_left_next;
  logic [7:0]          byte_count;
  logic [7:0]          byte_count_next;
  logic                emit;
  hdr_result_t         result;
  hdr_result_t         out_reg;

  // The parse step runs only when the result register can take its output.
  assign take = item_valid && (!out_valid || !out_stall);

  btlv_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .header_byte(header_byte),
    .restart    (restart),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  btlv_step #(
    .TAG_BITS         (TAG_BITS),
    .MAX_LENGTH_OCTETS(MAX_LENGTH_OCTETS)
  ) u_step (
    .item                  (item),
    .phase                 (phase),
    .saved_class           (saved_class),
    .saved_constructed     (saved_constructed),
    .tag_acc               (tag_acc),
    .len_acc               (len_acc),
    .octets_left           (octets_left),
    .byte_count            (byte_count),
    .phase_next            (phase_next),
    .saved_class_next      (saved_class_next),
    .saved_constructed_next(saved_constructed_next),
    .tag_acc_next          (tag_acc_next),
    .len_acc_next          (len_acc_next),
    .octets_left_next      (octets_left_next),
    .byte_count_next       (byte_count_next),
    .emit                  (emit),
    .result                (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDENT;
      saved_class <= '0;
      saved_constructed <= 1'b0;
      tag_acc <= '0;
      len_acc <= '0;
      octets_left <= '0;
      byte_count <= '0;
    end else if (take) begin
      phase <= phase_next;
      saved_class <= saved_class_next;
      saved_constructed <= saved_constructed_next;
      tag_acc <= tag_acc_next;
      len_acc <= len_acc_next;
      octets_left <= octets_left_next;
      byte_count <= byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_reg <= result;
    end
  end

  assign id_class = out_reg.id_class;
  assign constructed = out_reg.constructed;
  assign tag_number = out_reg.tag_number;
  assign content_length = out_reg.content_length;
  assign indefinite = out_reg.indefinite;
  assign header_size = out_reg.header_size;
  assign error_code = out_reg.error_code;

endmodule

// ----- tb/sv/tb_ber_tlv_header_parser_unit.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for ber_tlv_header_parser_unit: directed and random header bytes,
// with a byte-level header predictor and a checker for the result items.
// Depends on btlv_pkg and the ber_tlv_header_parser_unit RTL.
module tb_ber_tlv_header_parser_unit import btlv_pkg::*; ();

  localparam int CYCLE_LIMIT = 200_000;
  localparam int RANDOM_ITEMS = 260;
  localparam logic [63:0] TAG_MASK = {64{1'b1}} >> (64 - TAG_BITS_DEFAULT);
  localparam logic [7:0] MORE_OCTETS = 8'h80;

  // Directed headers: a long tag with bits beyond the tag width, the indefinite and
  // too-many-octets cases, an eight-octet length, and a restart in the middle of a header.
  localparam logic [7:0] DIRECTED_BYTES [27] = '{
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h7F,
    8'h04, 8'h80,
    8'h30, 8'h80,
    8'h02, 8'hFF,
    8'h82, 8'h88, 8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hAB, 8'hCD, 8'hEF,
    8'h3F, 8'h81, 8'h00, 8'h00
  };
  localparam logic [0:26] DIRECTED_RESTART = 27'b100000000000000000000000010;

  class header_scoreboard;
    hdr_result_t pending_headers[$];
    int failures;
    int headers_seen;
    logic [1:0] phase;
    logic [1:0] cur_class;
    logic cur_constructed;
    logic [63:0] tag_acc;
    logic [LEN_W-1:0] len_acc;
    logic [LEFT_W-1:0] octets_left;
    logic [7:0] octet_count;

    function new();
      failures = 0;
      headers_seen = 0;
      phase = PH_IDENT;
      cur_class = '0;
      cur_constructed = 1'b0;
      tag_acc = '0;
      len_acc = '0;
      octets_left = '0;
      octet_count = '0;
    endfunction

    function void finish_header(logic [LEN_W-1:0] len, logic indef, logic [1:0] err);
      hdr_result_t r;
      r.id_class = cur_class;
      r.constructed = cur_constructed;
      r.tag_number = tag_acc[TAG_OUT_W-1:0];
      r.content_length = len;
      r.indefinite = indef;
      r.header_size = octet_count;
      r.error_code = err;
      pending_headers.insert(pending_headers.size(), r);
      phase = PH_IDENT;
      octets_left = '0;
    endfunction

    // Advances the parse state by one accepted item.
    function void take_byte(logic [7:0] b, logic rs);
      logic [6:0] n;
      n = b[6:0];
      if (rs) phase = PH_IDENT;
      if (phase == PH_IDENT) begin
        cur_class = b[7:6];
        cur_constructed = b[5];
        len_acc = '0;
        octets_left = '0;
        octet_count = 8'd1;
        if (b[4:0] == TAG_LONG_FORM) begin
          phase = PH_TAG;
          tag_acc = '0;
        end else begin
          phase = PH_LEN0;
          tag_acc = {59'd0, b[4:0]} & TAG_MASK;
        end
        return;
      end
      if (octet_count != 8'hFF) octet_count = octet_count + 8'd1;
      case (phase)
        PH_TAG: begin
          tag_acc = ((tag_acc << 7) | {57'd0, n}) & TAG_MASK;
          if (!b[7]) phase = PH_LEN0;
        end
        PH_LEN0: begin
          if (!b[7]) begin
            finish_header({57'd0, n}, 1'b0, ERR_NONE);
          end else if (n == LEN_INDEFINITE) begin
            finish_header('0, 1'b1, cur_constructed ? ERR_NONE : ERR_PRIM_INDEF);
          end else if (n > MAX_LENGTH_OCTETS_DEFAULT) begin
            finish_header('0, 1'b0, ERR_TOO_MANY_OCTETS);
          end else begin
            len_acc = '0;
            octets_left = n[LEFT_W-1:0];
            phase = PH_LENX;
          end
        end
        default: begin
          len_acc = {len_acc[LEN_W-9:0], b};
          if (octets_left != 0) octets_left = octets_left - 1'b1;
          if (octets_left == 0) finish_header(len_acc, 1'b0, ERR_NONE);
        end
      endcase
    endfunction

    function void flag_field(string field, logic [63:0] exp, logic [63:0] act);
      failures++;
      if (failures <= 10)
        $display("header %0d: %s expected %0h, got %0h", headers_seen, field, exp, act);
    endfunction

    function void match_header(hdr_result_t got);
      hdr_result_t want;
      headers_seen++;
      if (pending_headers.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("header %0d: unexpected result, class %0d tag %0h", headers_seen,
                   got.id_class, got.tag_number);
        return;
      end
      want = pending_headers.pop_front();
      if (got.id_class !== want.id_class)
        flag_field("id_class", want.id_class, got.id_class);
      if (got.constructed !== want.constructed)
        flag_field("constructed", want.constructed, got.constructed);
      if (got.tag_number !== want.tag_number)
        flag_field("tag_number", want.tag_number, got.tag_number);
      if (got.content_length !== want.content_length)
        flag_field("content_length", want.content_length, got.content_length);
      if (got.indefinite !== want.indefinite)
        flag_field("indefinite", want.indefinite, got.indefinite);
      if (got.header_size !== want.header_size)
        flag_field("header_size", want.header_size, got.header_size);
      if (got.error_code !== want.error_code)
        flag_field("error_code", want.error_code, got.error_code);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] header_byte = 8'h00;
  logic restart = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] id_class;
  logic constructed;
  logic [TAG_OUT_W-1:0] tag_number;
  logic [LEN_W-1:0] content_length;
  logic indefinite;
  logic [7:0] header_size;
  logic [1:0] error_code;

  header_scoreboard sb = new();
  int send_burst = 0;

  ber_tlv_header_parser_unit i_dut (.*);

  always begin
    #10;
    clk = 1'b1;
    #10;
    clk = 1'b0;
  end

  // Offers one item after a random gap and returns at the edge that accepts it.
  task automatic send(input logic [7:0] b, input logic rs);
    int gap;
    if (send_burst > 0) begin
      gap = 0;
      send_burst--;
    end else begin
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 39) == 0) send_burst = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    header_byte <= b;
    restart <= rs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_byte(b, rs);
  endtask

  task automatic drain_headers();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_headers.size() != 0);
  endtask

  initial begin : stimulus
    item_t hdr[$];
    int random_items;
    int kind;
    int n;
    int cut;
    logic [7:0] id;
    bit paused;
    bit need_restart;
    random_items = 0;
    paused = 1'b0;
    need_restart = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 27; i++) send(DIRECTED_BYTES[i], DIRECTED_RESTART[i]);
    drain_headers();

    // A tag long enough to drive the header size into saturation.
    send({3'($urandom_range(0, 7)), TAG_LONG_FORM}, 1'b1);
    repeat (258) send(MORE_OCTETS | 8'($urandom_range(0, 127)), 1'b0);
    send(8'($urandom_range(0, 127)), 1'b0);
    send(8'($urandom_range(0, 127)), 1'b0);

    while (random_items < RANDOM_ITEMS) begin
      hdr.delete();
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
        // Noise: arbitrary bytes that may leave the parser anywhere.
        n = $urandom_range(1, 4);
        repeat (n) hdr.insert(hdr.size(), {8'($urandom), 1'($urandom_range(0, 1))});
        need_restart = 1'b1;
      end else begin
        id = 8'($urandom);
        if ($urandom_range(0, 3) == 0) id[4:0] = TAG_LONG_FORM;
        hdr.insert(hdr.size(), {id, need_restart | 1'($urandom_range(0, 1))});
        if (id[4:0] == TAG_LONG_FORM) begin
          n = $urandom_range(0, 5);
          repeat (n)
            hdr.insert(hdr.size(), {MORE_OCTETS | 8'($urandom_range(0, 127)), 1'b0});
          hdr.insert(hdr.size(), {8'($urandom_range(0, 127)), 1'b0});
        end
        case ($urandom_range(0, 5))
          0, 1: hdr.insert(hdr.size(), {8'($urandom_range(0, 127)), 1'b0});
          2: hdr.insert(hdr.size(), {1'b1, LEN_INDEFINITE, 1'b0});
          3: hdr.insert(hdr.size(),
                        {MORE_OCTETS | 8'($urandom_range(MAX_LENGTH_OCTETS_DEFAULT + 1, 127)),
                         1'b0});
          default: begin
            n = $urandom_range(1, MAX_LENGTH_OCTETS_DEFAULT);
            hdr.insert(hdr.size(), {MORE_OCTETS | 8'(n), 1'b0});
            repeat (n) hdr.insert(hdr.size(), {8'($urandom), 1'b0});
          end
        endcase
        need_restart = 1'b0;
        // A broken header stops short; the next one must restart the parser.
        if (kind == 8 && hdr.size() > 1) begin
          cut = $urandom_range(1, hdr.size() - 1);
          while (hdr.size() > cut) void'(hdr.pop_back());
          need_restart = 1'b1;
        end
      end
      foreach (hdr[j]) send(hdr[j].header_byte, hdr[j].restart);
      random_items += hdr.size();
      if (!paused && random_items >= RANDOM_ITEMS / 2) begin
        drain_headers();
        paused = 1'b1;
      end
    end

    drain_headers();
    repeat (8) @(posedge clk);
    if (sb.failures == 0 && sb.pending_headers.size() == 0) begin
      $display("PASS ber_tlv_header_parser_unit");
    end else begin
      $display("FAIL ber_tlv_header_parser_unit");
    end
    $finish;
  end

  initial begin : result_sink
    hdr_result_t got;
    int wait_left;
    int recv_burst;
    bit long_hold_done;
    wait_left = 0;
    recv_burst = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (out_valid && !out_stall) begin
          got.id_class = id_class;
          got.constructed = constructed;
          got.tag_number = tag_number;
          got.content_length = content_length;
          got.indefinite = indefinite;
          got.header_size = header_size;
          got.error_code = error_code;
          sb.match_header(got);
          if (recv_burst > 0) begin
            wait_left = 0;
            recv_burst--;
          end else begin
            wait_left = $urandom_range(0, 6);
            if ($urandom_range(0, 29) == 0) recv_burst = $urandom_range(10, 40);
          end
          // One long hold-off so the block fills up and stalls its input.
          if (!long_hold_done && sb.headers_seen == 20) begin
            wait_left = 300;
            long_hold_done = 1'b1;
          end
        end else if (wait_left > 0) begin
          wait_left--;
        end
        out_stall <= (wait_left > 0);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL ber_tlv_header_parser_unit");
    $finish;
  end

endmodule
